### hw/rtl/mpwm_pkg.sv
// Shared constants and types for the multichannel PWM with serial command block.
`default_nettype none
package mpwm_pkg;

	localparam int CHANNELS    = 3;
	localparam int LEVEL_COUNT = 3;
	localparam int CH_USED     = (CHANNELS < LEVEL_COUNT) ? CHANNELS : LEVEL_COUNT;
	localparam int PERIOD      = 256;
	localparam int CNT_W       = (PERIOD > 2) ? $clog2(PERIOD) : 1;
	localparam int BYTE_BITS   = 8;
	localparam int BIT_IDX_W   = 3;
	localparam int LEVEL_W     = 16;
	localparam int DRIVE_W     = 3;

	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 16;

	typedef enum logic [1:0] {
		PROG_NONE  = 2'd0,
		PROG_TEST  = 2'd1,
		PROG_PULSE = 2'd2,
		PROG_SWEEP = 2'd3
	} prog_sel_t;

	typedef logic [LEVEL_COUNT-1:0][LEVEL_W-1:0] level_arr_t;

	typedef struct packed {
		logic                 loaded;
		prog_sel_t            prog_sel;
		logic [BYTE_BITS-1:0] cmd_byte;
	} cmd_status_t;

endpackage
`default_nettype wire

### hw/rtl/mpwm_serial.sv
// Serial command receiver: LSB-first byte shifter and program select register.
`default_nettype none
module mpwm_serial (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  en,
	input  wire                  clock_level,
	input  wire                  data_level,
	output mpwm_pkg::cmd_status_t status_next
);
	import mpwm_pkg::*;

	logic [BYTE_BITS-1:0] shift_q;
	logic [BIT_IDX_W-1:0] bit_idx_q;
	logic                 last_clk_q;
	prog_sel_t            prog_q;
	logic [BYTE_BITS-1:0] last_byte_q;

	logic [BYTE_BITS-1:0] shift_d;
	logic [BIT_IDX_W-1:0] bit_idx_d;
	prog_sel_t            prog_d;
	logic [BYTE_BITS-1:0] last_byte_d;
	logic [BYTE_BITS-1:0] merged;
	logic                 rise;
	logic                 done;

	always_comb begin
		rise        = clock_level && !last_clk_q;
		merged      = shift_q | (BYTE_BITS'(data_level) << bit_idx_q);
		done        = 1'b0;
		shift_d     = shift_q;
		bit_idx_d   = bit_idx_q;
		prog_d      = prog_q;
		last_byte_d = last_byte_q;
		if (rise) begin
			if (bit_idx_q == BIT_IDX_W'(BYTE_BITS - 1)) begin
				done        = 1'b1;
				last_byte_d = merged;
				// unknown commands keep the old program
				if (merged[BYTE_BITS-1:2] == '0) begin
					prog_d = prog_sel_t'(merged[1:0]);
				end
				shift_d   = '0;
				bit_idx_d = '0;
			end else begin
				shift_d   = merged;
				bit_idx_d = bit_idx_q + BIT_IDX_W'(1);
			end
		end
	end

	assign status_next.loaded   = done;
	assign status_next.prog_sel = prog_d;
	assign status_next.cmd_byte = last_byte_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q     <= '0;
			bit_idx_q   <= '0;
			last_clk_q  <= 1'b0;
			prog_q      <= PROG_PULSE;
			last_byte_q <= '0;
		end else if (en) begin
			shift_q     <= shift_d;
			bit_idx_q   <= bit_idx_d;
			last_clk_q  <= clock_level;
			prog_q      <= prog_d;
			last_byte_q <= last_byte_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_byte_restart: assert property (@(posedge clk) disable iff (!arst_n)
		en && done |=> bit_idx_q == '0 && shift_q == '0)
		else $error("shifter not cleared after a complete byte");
`endif

endmodule
`default_nettype wire

### hw/rtl/mpwm_engine.sv
// PWM period counter, per-channel on-time latches and drive bits.
`default_nettype none
module mpwm_engine (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          en,
	input  wire                          tick,
	input  wire                          restart,
	input  wire mpwm_pkg::level_arr_t    levels,
	input  wire [mpwm_pkg::DRIVE_W-1:0] ch_disable,
	output logic [mpwm_pkg::DRIVE_W-1:0] drive_next
);
	import mpwm_pkg::*;

	logic [CNT_W-1:0]                 pc_q;
	logic [LEVEL_COUNT-1:0][7:0]      on_q;
	logic [DRIVE_W-1:0]               drive_q;

	logic [CNT_W-1:0]                 pc_base;
	logic [CNT_W:0]                   pc_inc;
	logic                             wrap;
	logic [CNT_W-1:0]                 pc_d;
	logic [LEVEL_COUNT-1:0][7:0]      on_d;
	logic [DRIVE_W-1:0]               drive_d;

	always_comb begin
		// a completed command restarts the period so the next tick latches
		pc_base = restart ? CNT_W'(PERIOD - 1) : pc_q;
		pc_inc  = {1'b0, pc_base} + (CNT_W+1)'(1);
		wrap    = tick && (pc_inc >= (CNT_W+1)'(PERIOD));
		if (!tick) begin
			pc_d = pc_base;
		end else if (wrap) begin
			pc_d = '0;
		end else begin
			pc_d = pc_inc[CNT_W-1:0];
		end
		on_d    = on_q;
		drive_d = '0;
		for (int i = 0; i < DRIVE_W; i++) begin
			if (i < CH_USED) begin
				drive_d[i] = drive_q[i];
				if (wrap) begin
					on_d[i]    = levels[i][LEVEL_W-1 -: 8];
					drive_d[i] = (levels[i][LEVEL_W-1 -: 8] != 8'd0) && !ch_disable[i];
				end
				if (tick && ({{(9-CNT_W){1'b0}}, pc_d} == {1'b0, on_d[i]})) begin
					drive_d[i] = 1'b0;
				end
			end
		end
	end

	assign drive_next = drive_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= '0;
			on_q    <= '0;
			drive_q <= '0;
		end else if (en) begin
			pc_q    <= pc_d;
			on_q    <= on_d;
			drive_q <= drive_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_restart_count: assert property (@(posedge clk) disable iff (!arst_n)
		en && restart && !tick |=> pc_q == CNT_W'(PERIOD - 1))
		else $error("period restart did not preset the counter");
`endif

endmodule
`default_nettype wire

### hw/rtl/multichannel_pwm_with_serial_command_core.sv
// Top level: input register, serial receiver, PWM engine and result register.
//
//  channel  | dir | fields (low bit up)
//  s_axis   | in  | tdata: timer_tick, clock_level, data_level, level_ch0, level_ch1, level_ch2
//  m_axis   | out | tdata: channel_drive, program_select, program_loaded, command_byte
//  cfg      | in  | cfg_wr_en / cfg_wr_data: channel_disable
//
// One item per cycle while the result is not stalled; an accepted item passes through the input
// register, then the result register that holds the updated state.
// Reset is asynchronous and active low; program resets to pulse, other state to zero (input/result data not reset).
// A stalled result holds the pipeline: the input register takes an item whenever it
// is empty or moves on into the result register in the same cycle.
`default_nettype none
module multichannel_pwm_with_serial_command_core (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_axis_tvalid,
	output logic                                s_axis_tready,
	// timer_tick[0], clock_level[1], data_level[2], level_ch0[18:3],
	// level_ch1[34:19], level_ch2[50:35], zero pad
	input  wire [mpwm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  wire                                 m_axis_tready,
	// channel_drive[2:0], program_select[4:3], program_loaded[5], command_byte[13:6],
	// zero pad
	output logic [mpwm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	input  wire                                 cfg_wr_en,
	input  wire [mpwm_pkg::DRIVE_W-1:0]        cfg_wr_data
);
	import mpwm_pkg::*;

	logic                    valid_s1;
	logic                    tick_s1;
	logic                    clk_lvl_s1;
	logic                    dat_lvl_s1;
	level_arr_t              levels_s1;

	logic                    out_valid_q;
	logic [OUT_TDATA_W-1:0]  out_data_q;
	logic [DRIVE_W-1:0]      disable_q;

	logic                    advance;
	logic                    take_in;
	cmd_status_t             status_next;
	logic [DRIVE_W-1:0]      drive_next;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign take_in       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disable_q <= '0;
		end else if (cfg_wr_en) begin
			disable_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			tick_s1      <= s_axis_tdata[0];
			clk_lvl_s1   <= s_axis_tdata[1];
			dat_lvl_s1   <= s_axis_tdata[2];
			levels_s1[0] <= s_axis_tdata[18:3];
			levels_s1[1] <= s_axis_tdata[34:19];
			levels_s1[2] <= s_axis_tdata[50:35];
		end
	end

	mpwm_serial u_serial (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (advance),
		.clock_level (clk_lvl_s1),
		.data_level  (dat_lvl_s1),
		.status_next (status_next)
	);

	mpwm_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.tick       (tick_s1),
		.restart    (status_next.loaded),
		.levels     (levels_s1),
		.ch_disable (disable_q),
		.drive_next (drive_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {2'b00, status_next.cmd_byte, status_next.loaded,
				status_next.prog_sel, drive_next};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`ifndef NO_ASSERTIONS
	a_ready_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && out_valid_q && !m_axis_tready)
		else $error("input stalled without a blocked result");

	a_known_cmd_selects: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[5] && m_axis_tdata[13:8] == 6'd0
		|-> m_axis_tdata[4:3] == m_axis_tdata[7:6])
		else $error("known command did not select its program");

	a_advance_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed item produced no result");
`endif

endmodule
`default_nettype wire
